>>> rtl/core/spbc_pkg.sv
package spbc_pkg;

    localparam int LEN_W = 16;

    localparam logic [3:0] PACK_GROUP   = 4'd7;
    localparam logic [3:0] UNPACK_GROUP = 4'd8;
    localparam logic [7:0] HIGH_INIT    = 8'h80;
    localparam logic [2:0] MAX_POS      = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REM,
        ST_STEP,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic             first_byte;
        logic [LEN_W-1:0] message_length;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_item_t;

    // sequencer -> group datapath
    typedef struct packed {
        logic       step;
        logic       clear;
        logic       dir;
        logic       first;
        logic [2:0] rem;
        logic [7:0] data;
    } grp_ctrl_t;

    // group datapath -> sequencer, valid for the item being stepped
    typedef struct packed {
        logic       emit;
        logic       pack_done;
        logic [7:0] data;
        logic [3:0] size;
    } grp_res_t;

endpackage

>>> rtl/core/seven_bit_packing_codec.sv
// Eight-to-seven bit packing codec.
// src channel: one byte per item, with first_byte marking a message start and
// message_length read on that item. dst channel: converted bytes, with
// last_of_run set on the final byte caused by one input item.
// direction (cfg_wen/cfg_wdata) picks pack (0) or unpack (1); a write drops any
// half-built group. Write it only while the block is idle.
// Each item is accepted and then stepped into the group. The first item of a
// pack message waits first for length mod 7 from the three-bit remainder unit.
// A completed pack group of g bytes sends its collector byte, then drains the
// g buffered bytes one per cycle while dst_stall is low; src stays stalled
// while it drains. Unpack gives at most one byte per item.
// dst holds its item while dst_stall is high; the sequencer waits on it.
// Reset clears direction to pack and the group state; the group buffer itself
// is not cleared and is always written before it is read.
module seven_bit_packing_codec (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wen,
    input  logic                 cfg_wdata,
    input  logic                 src_valid,
    output logic                 src_stall,
    input  spbc_pkg::in_item_t   src_item,
    output logic                 dst_valid,
    input  logic                 dst_stall,
    output spbc_pkg::out_item_t  dst_item
);

    spbc_pkg::state_t    state_reg, state_next;
    spbc_pkg::in_item_t  in_reg;
    spbc_pkg::out_item_t out_reg, out_next;
    spbc_pkg::grp_ctrl_t ctrl;
    spbc_pkg::grp_res_t  res;

    logic       dir_reg;
    logic       out_valid_reg, out_valid_next;
    logic [2:0] drain_idx_reg, drain_idx_next;
    logic [3:0] drain_size_reg, drain_size_next;
    logic       in_take, out_load, load, drain_last, rem_start, rem_done;
    logic [2:0] rem7, rd_idx;
    logic [6:0] rd_data;

    assign src_stall  = (state_reg != spbc_pkg::ST_IDLE);
    assign in_take    = src_valid && !src_stall;
    assign out_load   = !out_valid_reg || !dst_stall;
    assign rem_start  = in_take && src_item.first_byte && !dir_reg;
    assign drain_last = ({1'b0, drain_idx_reg} + 4'd1) == drain_size_reg;
    // buffer read is registered, so address the byte needed next cycle
    assign rd_idx     = drain_idx_next;

    spbc_rem7 u_rem7 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rem_start),
        .value (src_item.message_length),
        .done  (rem_done),
        .rem   (rem7)
    );

    spbc_group u_group (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .rd_idx  (rd_idx),
        .rd_data (rd_data),
        .res     (res)
    );

    always_comb
    begin
        state_next      = state_reg;
        out_next        = out_reg;
        load            = 1'b0;
        drain_idx_next  = drain_idx_reg;
        drain_size_next = drain_size_reg;

        ctrl       = '0;
        ctrl.clear = cfg_wen;
        ctrl.dir   = dir_reg;
        ctrl.first = in_reg.first_byte;
        ctrl.rem   = dir_reg ? in_reg.message_length[2:0] : rem7;
        ctrl.data  = in_reg.data_byte;

        unique case (state_reg)
            spbc_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = rem_start ? spbc_pkg::ST_REM : spbc_pkg::ST_STEP;
                end
            end
            spbc_pkg::ST_REM:
            begin
                if (rem_done)
                begin
                    state_next = spbc_pkg::ST_STEP;
                end
            end
            spbc_pkg::ST_STEP:
            begin
                if (!res.emit && !res.pack_done)
                begin
                    ctrl.step  = 1'b1;
                    state_next = spbc_pkg::ST_IDLE;
                end
                else if (out_load)
                begin
                    ctrl.step            = 1'b1;
                    load                 = 1'b1;
                    out_next.out_byte    = res.data;
                    out_next.last_of_run = !res.pack_done;
                    if (res.pack_done)
                    begin
                        // collector went out, buffered bytes follow
                        drain_idx_next  = 3'd0;
                        drain_size_next = res.size;
                        state_next      = spbc_pkg::ST_DRAIN;
                    end
                    else
                    begin
                        state_next = spbc_pkg::ST_IDLE;
                    end
                end
            end
            spbc_pkg::ST_DRAIN:
            begin
                if (out_load)
                begin
                    load                 = 1'b1;
                    out_next.out_byte    = {1'b1, rd_data};
                    out_next.last_of_run = drain_last;
                    if (drain_last)
                    begin
                        state_next = spbc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        drain_idx_next = drain_idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = spbc_pkg::ST_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!dst_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= spbc_pkg::ST_IDLE;
            out_valid_reg  <= 1'b0;
            dir_reg        <= 1'b0;
            drain_idx_reg  <= 3'd0;
            drain_size_reg <= 4'd0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            drain_idx_reg  <= drain_idx_next;
            drain_size_reg <= drain_size_next;
            if (cfg_wen)
            begin
                dir_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_reg <= src_item;
        end
        out_reg <= out_next;
    end

    assign dst_valid = out_valid_reg;
    assign dst_item  = out_reg;

    a_drain_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == spbc_pkg::ST_DRAIN |-> {1'b0, drain_idx_reg} < drain_size_reg)
        else $error("drain index past group size");

    a_rem_only_waited: assert property (@(posedge clk) disable iff (!rst_n)
        rem_done |-> state_reg == spbc_pkg::ST_REM)
        else $error("remainder finished outside its wait state");

    a_drain_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == spbc_pkg::ST_DRAIN && out_load && drain_last
        |=> state_reg == spbc_pkg::ST_IDLE && dst_valid && dst_item.last_of_run)
        else $error("drain did not end on a last byte");

    a_collector_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == spbc_pkg::ST_STEP && load && res.pack_done
        |=> dst_valid && !dst_item.last_of_run)
        else $error("pack collector flagged as last");

endmodule

>>> rtl/core/spbc_rem7.sv
// Length mod 7, three bits per cycle: since 8 == 1 (mod 7), the remainder is the
// running sum of octal digits, folded back below 7 after each add.
module spbc_rem7 (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [spbc_pkg::LEN_W-1:0]  value,
    output logic                        done,
    output logic [2:0]                  rem
);

    localparam int STEPS = (spbc_pkg::LEN_W + 2) / 3;
    localparam int PAD   = STEPS * 3;
    localparam int CW    = $clog2(STEPS + 1);

    logic [PAD-1:0] val_reg, val_next;
    logic [2:0]     acc_reg, acc_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [3:0]     sum;

    always_comb
    begin
        val_next  = val_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        sum       = {1'b0, acc_reg} + {1'b0, val_reg[2:0]};
        if (start)
        begin
            val_next  = PAD'(value);
            acc_next  = 3'd0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = (sum >= spbc_pkg::PACK_GROUP) ? 3'(sum - spbc_pkg::PACK_GROUP)
                                                     : sum[2:0];
            val_next = val_reg >> 3;
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign rem  = acc_reg;

endmodule

>>> rtl/core/spbc_group.sv
// Group state: buffered low bits, collector byte, group size and fill count.
module spbc_group (
    input  logic                  clk,
    input  logic                  rst_n,
    input  spbc_pkg::grp_ctrl_t   ctrl,
    input  logic [2:0]            rd_idx,
    output logic [6:0]            rd_data,
    output spbc_pkg::grp_res_t    res
);

    logic [6:0] store_reg [7];
    logic [6:0] rd_data_reg;
    logic [7:0] hb_reg, hb_next;
    logic [3:0] gs_reg, gs_next;
    logic [3:0] cnt_reg, cnt_next;

    logic [3:0] full, first_gs, eff_gs, eff_cnt, cnt_inc, pos;
    logic [7:0] eff_hb, hb_new;
    logic       gs_bad, clr, grp_end, wr_en;

    always_comb
    begin
        full     = ctrl.dir ? spbc_pkg::UNPACK_GROUP : spbc_pkg::PACK_GROUP;
        first_gs = (ctrl.rem == 3'd0) ? full : {1'b0, ctrl.rem};
        gs_bad   = (gs_reg == 4'd0) || (gs_reg > full);
        eff_gs   = ctrl.first ? first_gs : (gs_bad ? full : gs_reg);
        clr      = ctrl.first || gs_bad || (cnt_reg >= eff_gs);
        eff_cnt  = clr ? 4'd0 : cnt_reg;
        eff_hb   = clr ? spbc_pkg::HIGH_INIT : hb_reg;
        pos      = {1'b0, spbc_pkg::MAX_POS} - eff_gs + eff_cnt;
        cnt_inc  = eff_cnt + 4'd1;
        grp_end  = (cnt_inc >= eff_gs);

        res = '0;
        res.size = eff_gs;
        if (ctrl.dir)
        begin
            // first byte of an unpack group is the collector itself
            hb_new   = (eff_cnt == 4'd0) ? ctrl.data : eff_hb;
            res.emit = (eff_cnt != 4'd0);
            res.data = {eff_hb[pos[2:0]], ctrl.data[6:0]};
        end
        else
        begin
            hb_new        = eff_hb | (8'(ctrl.data[7]) << pos[2:0]);
            res.pack_done = grp_end;
            res.data      = hb_new;
        end

        hb_next  = hb_reg;
        gs_next  = gs_reg;
        cnt_next = cnt_reg;
        if (ctrl.clear)
        begin
            hb_next  = spbc_pkg::HIGH_INIT;
            gs_next  = 4'd0;
            cnt_next = 4'd0;
        end
        else if (ctrl.step)
        begin
            if (grp_end)
            begin
                hb_next  = spbc_pkg::HIGH_INIT;
                gs_next  = full;
                cnt_next = 4'd0;
            end
            else
            begin
                hb_next  = hb_new;
                gs_next  = eff_gs;
                cnt_next = cnt_inc;
            end
        end
    end

    assign wr_en = ctrl.step && !ctrl.clear && !ctrl.dir;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hb_reg  <= spbc_pkg::HIGH_INIT;
            gs_reg  <= 4'd0;
            cnt_reg <= 4'd0;
        end
        else
        begin
            hb_reg  <= hb_next;
            gs_reg  <= gs_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[eff_cnt[2:0]] <= ctrl.data[6:0];
        end
        // a byte written at this edge is read straight from the input
        if (wr_en && (eff_cnt[2:0] == rd_idx))
        begin
            rd_data_reg <= ctrl.data[6:0];
        end
        else
        begin
            rd_data_reg <= store_reg[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam logic DIR_PACK   = 1'b0;
    localparam logic DIR_UNPACK = 1'b1;

    localparam int SETTLE_CYCLES  = 24;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int LONG_HOLD      = 70;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wen;
    logic                 cfg_wdata;
    logic                 src_valid;
    logic                 src_stall;
    spbc_pkg::in_item_t   src_item;
    logic                 dst_valid;
    logic                 dst_stall;
    spbc_pkg::out_item_t  dst_item;

    // shared between the sender, the receiver and the tests
    bit         quiet;
    int         long_hold;
    int         mismatches;

    // predicted codec state
    logic       cur_dir;
    logic [6:0] grp_lo [7];
    logic [7:0] hi_bits;
    logic [3:0] grp_size;
    logic [3:0] grp_taken;

    spbc_pkg::out_item_t  pending_bytes [$];
    spbc_pkg::out_item_t  want_byte;

    seven_bit_packing_codec dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_item  (dst_item)
    );

    always #6 clk = ~clk;

    function automatic void clear_group();
        hi_bits   = spbc_pkg::HIGH_INIT;
        grp_taken = 4'd0;
    endfunction

    function automatic void push_result(input logic [7:0] b, input logic last);
        spbc_pkg::out_item_t o;
        o.out_byte    = b;
        o.last_of_run = last;
        pending_bytes.push_back(o);
    endfunction

    // Works out the bytes that one accepted item causes.
    function automatic void predict_conversion(input spbc_pkg::in_item_t it);
        logic [3:0]                 full;
        logic [spbc_pkg::LEN_W-1:0] rem;
        int                         pos;
        full = (cur_dir == DIR_UNPACK) ? spbc_pkg::UNPACK_GROUP : spbc_pkg::PACK_GROUP;
        if (it.first_byte) begin
            rem = it.message_length % spbc_pkg::LEN_W'(full);
            clear_group();
            grp_size = (rem == '0) ? full : rem[3:0];
        end
        else if (grp_size == 4'd0 || grp_size > full) begin
            clear_group();
            grp_size = full;
        end
        if (grp_taken >= grp_size)
            clear_group();

        if (cur_dir == DIR_PACK) begin
            if (grp_taken < grp_size && grp_taken < 4'd7) begin
                grp_lo[grp_taken] = it.data_byte[6:0];
                pos = 7 - int'(grp_size) + int'(grp_taken);
                hi_bits[pos] = hi_bits[pos] | it.data_byte[7];
                grp_taken++;
                if (grp_taken == grp_size) begin
                    push_result(hi_bits, 1'b0);
                    for (int k = 0; k < int'(grp_size); k++)
                        push_result({1'b1, grp_lo[k]}, k == int'(grp_size) - 1);
                    clear_group();
                    grp_size = spbc_pkg::PACK_GROUP;
                end
            end
        end
        else begin
            if (grp_taken < grp_size) begin
                if (grp_taken == 4'd0) begin
                    hi_bits = it.data_byte;   // collector byte, no output
                end
                else begin
                    pos = 7 - int'(grp_size) + int'(grp_taken);
                    push_result({hi_bits[pos], it.data_byte[6:0]}, 1'b1);
                end
                grp_taken++;
                if (grp_taken >= grp_size) begin
                    clear_group();
                    grp_size = spbc_pkg::UNPACK_GROUP;
                end
            end
        end
    endfunction

    task automatic src_idle(input int n);
        @(negedge clk);
        src_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic push_item(input logic [7:0] b, input logic first,
                             input logic [spbc_pkg::LEN_W-1:0] len);
        spbc_pkg::in_item_t it;
        it.data_byte      = b;
        it.first_byte     = first;
        it.message_length = len;
        if (!quiet && $urandom_range(0, 4) == 0)
            src_idle($urandom_range(1, 18));
        @(negedge clk);
        src_item  <= it;
        src_valid <= 1'b1;
        @(posedge clk);
        while (src_stall) @(posedge clk);
        predict_conversion(it);
    endtask

    // Drop valid, wait for every predicted byte, then let the block settle.
    task automatic wait_idle();
        src_idle(1);
        while (pending_bytes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_direction(input logic d);
        wait_idle();
        @(negedge clk);
        cfg_wdata <= d;
        cfg_wen   <= 1'b1;
        @(negedge clk);
        cfg_wen   <= 1'b0;
        cur_dir  = d;
        clear_group();
        grp_size = 4'd0;
    endtask

    // Pack: bytes before any message start, then a zero-length message.
    task automatic test_pack_without_message();
        push_item(8'h80, 1'b0, 16'hFFFF);
        push_item(8'h7F, 1'b0, 16'h0000);
        push_item(8'hFF, 1'b1, 16'd0);
        push_item(8'h00, 1'b0, 16'h5555);
        push_item(8'h80, 1'b0, 16'hAAAA);
        push_item(8'h7F, 1'b0, 16'h0000);
        push_item(8'h01, 1'b0, 16'hFFFF);
        push_item(8'hFE, 1'b0, 16'h0000);
        push_item(8'hAA, 1'b0, 16'h0000);
    endtask

    // Pack: extreme lengths, a short message and a byte past its end.
    task automatic test_pack_lengths();
        push_item(8'hFF, 1'b1, 16'd65535);
        push_item(8'h00, 1'b1, 16'd1);
        push_item(8'hA5, 1'b1, 16'd3);
        push_item(8'h5A, 1'b0, 16'd0);
        push_item(8'hFF, 1'b0, 16'd0);
        push_item(8'h81, 1'b0, 16'd0);   // opens a group that the next write drops
    endtask

    task automatic test_unpack_edges();
        set_direction(DIR_UNPACK);
        push_item(8'h01, 1'b0, 16'd0);
        push_item(8'h55, 1'b0, 16'd0);
        // lone collector: no output
        push_item(8'hFF, 1'b1, 16'd9);
        push_item(8'h60, 1'b1, 16'd3);
        push_item(8'h00, 1'b0, 16'd0);
        push_item(8'h7F, 1'b0, 16'd0);
        // half-built group, dropped by the write below
        push_item(8'hC3, 1'b1, 16'd5);
        push_item(8'h3C, 1'b0, 16'd0);
        set_direction(DIR_PACK);
    endtask

    // Receiver holds off while the sender keeps going, so src backs up.
    task automatic test_backpressure();
        quiet     = 1'b1;
        long_hold = LONG_HOLD;
        push_item(8'($urandom), 1'b1, 16'd21);
        for (int i = 1; i < 21; i++)
            push_item(8'($urandom), 1'b0, spbc_pkg::LEN_W'($urandom));
        wait_idle();
        quiet = 1'b0;
    endtask

    task automatic test_random_traffic(input logic dir, input int n_items, input bit calm);
        int sent;
        int kind;
        int len;
        int nb;
        set_direction(dir);
        sent = 0;
        while (sent < n_items) begin
            quiet = calm || ($urandom_range(0, 3) == 0);
            kind  = $urandom_range(0, 9);
            if (kind >= 8) begin
                push_item(8'($urandom), 1'b0, spbc_pkg::LEN_W'($urandom));
                sent++;
            end
            else begin
                if ($urandom_range(0, 4) == 0)
                    len = $urandom_range(0, 65535);
                else
                    len = $urandom_range(1, 20);
                nb = (len < 1 || len > 24) ? $urandom_range(1, 24) : len;
                if (kind == 7)
                    nb = $urandom_range(1, nb);   // message cut short
                if (nb > n_items - sent)
                    nb = n_items - sent;
                push_item(8'($urandom), 1'b1, spbc_pkg::LEN_W'(len));
                for (int i = 1; i < nb; i++)
                    push_item(8'($urandom), 1'b0, spbc_pkg::LEN_W'($urandom));
                sent += nb;
            end
        end
        quiet = calm;
    endtask

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        cfg_wen    = 1'b0;
        cfg_wdata  = 1'b0;
        src_valid  = 1'b0;
        src_item   = '0;
        quiet      = 1'b0;
        long_hold  = 0;
        mismatches = 0;
        cur_dir    = DIR_PACK;
        hi_bits    = spbc_pkg::HIGH_INIT;
        grp_size   = 4'd0;
        grp_taken  = 4'd0;
        for (int k = 0; k < 7; k++)
            grp_lo[k] = 7'd0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_pack_without_message();
        test_pack_lengths();
        test_unpack_edges();
        test_backpressure();
        test_random_traffic(DIR_PACK, 20, 1'b0);
        test_random_traffic(DIR_UNPACK, 20, 1'b0);
        // last part runs without idling
        test_random_traffic(DIR_PACK, 13, 1'b1);
        test_random_traffic(DIR_UNPACK, 13, 1'b1);
        wait_idle();

        if (mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // dst side: random stall bursts, or one long hold when a test asks
    initial
    begin
        dst_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold > 0) begin
                dst_stall <= 1'b1;
                repeat (long_hold) @(negedge clk);
                dst_stall <= 1'b0;
                long_hold = 0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0) begin
                dst_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                dst_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && dst_valid && !dst_stall) begin
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected item, out_byte %02h last_of_run %0b",
                         $time, dst_item.out_byte, dst_item.last_of_run);
                mismatches++;
            end
            else begin
                want_byte = pending_bytes.pop_front();
                if (dst_item.out_byte !== want_byte.out_byte) begin
                    $display("%0t: out_byte expected %02h, got %02h",
                             $time, want_byte.out_byte, dst_item.out_byte);
                    mismatches++;
                end
                if (dst_item.last_of_run !== want_byte.last_of_run) begin
                    $display("%0t: last_of_run expected %0b, got %0b",
                             $time, want_byte.last_of_run, dst_item.last_of_run);
                    mismatches++;
                end
            end
        end
    end

    // ends a hung run: too many cycles with no item moving on either side
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((src_valid && !src_stall) || (dst_valid && !dst_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

endmodule
